// ===== hw/rtl/lswc_pkg.sv =====
package lswc_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int PARAM_SCALE_DEF = 1000;

  localparam int WIN_LEFT_RST   = 0;
  localparam int WIN_RIGHT_RST  = 320;
  localparam int WIN_BOTTOM_RST = 0;
  localparam int WIN_TOP_RST    = 240;

  localparam int CFG_IDX_WIDTH = 2;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_WINDOW_LEFT   = 2'd0,
    REG_WINDOW_RIGHT  = 2'd1,
    REG_WINDOW_BOTTOM = 2'd2,
    REG_WINDOW_TOP    = 2'd3
  } cfg_reg_e;

endpackage

// ===== hw/rtl/lswc_div.sv =====
module lswc_div #(
  parameter int DW = 26,
  parameter int VW = 16
) (
  input  logic          clk_i,
  input  logic [DW-1:0] num_i,
  input  logic [VW-1:0] den_i,
  output logic [DW-1:0] quo_o
);

  logic [DW-1:0] num_q [0:DW];
  logic [VW-1:0] den_q [0:DW];
  logic [VW-1:0] rem_q [0:DW];
  logic [DW-1:0] quo_q [0:DW];

  always_ff @(posedge clk_i) begin
    num_q[0] <= num_i;
    den_q[0] <= den_i;
    rem_q[0] <= '0;
    quo_q[0] <= '0;
  end

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [VW:0] trial;
    logic        fit;
    assign trial = {rem_q[i], num_q[i][DW-1]};
    assign fit   = trial >= {1'b0, den_q[i]};
    always_ff @(posedge clk_i) begin
      num_q[i+1] <= {num_q[i][DW-2:0], 1'b0};
      den_q[i+1] <= den_q[i];
      rem_q[i+1] <= fit ? VW'(trial - {1'b0, den_q[i]}) : VW'(trial);
      quo_q[i+1] <= {quo_q[i][DW-2:0], fit};
    end
  end

  assign quo_o = quo_q[DW];

endmodule

// ===== hw/rtl/lswc_pipe.sv =====
module lswc_pipe #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] tap_q [0:DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) tap_q[i] <= '0;
    end else begin
      tap_q[0] <= data_i;
      for (int i = 1; i < DEPTH; i++) tap_q[i] <= tap_q[i-1];
    end
  end

  assign data_o = tap_q[DEPTH-1];

endmodule

// ===== hw/rtl/line_segment_window_clipper.sv =====
// Liang-Barsky segment clipper, fully pipelined: one segment is accepted in
// every cycle (busy_o stays low) and its result appears on done_o. The edge
// parameters come from a bit-per-stage divider; the endpoint rescale is a
// registered reciprocal multiplication. Results cannot be held off; a
// rejected segment reports visible_o low and zero coordinates. Window
// registers are written through cfg_we_i and take effect on items accepted
// afterwards.
module line_segment_window_clipper #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF,
  parameter int PARAM_SCALE = lswc_pkg::PARAM_SCALE_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  output logic                                   busy_o,
  input  logic signed [COORD_WIDTH-1:0]          start_x_i,
  input  logic signed [COORD_WIDTH-1:0]          start_y_i,
  input  logic signed [COORD_WIDTH-1:0]          end_x_i,
  input  logic signed [COORD_WIDTH-1:0]          end_y_i,
  input  logic                                   cfg_we_i,
  input  logic [lswc_pkg::CFG_IDX_WIDTH-1:0]     cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]                 cfg_wdata_i,
  output logic                                   done_o,
  output logic                                   visible_o,
  output logic signed [COORD_WIDTH-1:0]          clip_start_x_o,
  output logic signed [COORD_WIDTH-1:0]          clip_start_y_o,
  output logic signed [COORD_WIDTH-1:0]          clip_end_x_o,
  output logic signed [COORD_WIDTH-1:0]          clip_end_y_o
);

  localparam int W   = COORD_WIDTH;
  localparam int SW  = $clog2(PARAM_SCALE + 1);
  localparam int QW  = W + SW;
  localparam int RW  = SW + 2;
  localparam int PW  = SW + W;
  localparam int SB1 = 1 + 4 * W + 12;
  localparam int SB2 = 6 + 4 * W;
  localparam int RS  = PW + $clog2(PARAM_SCALE);
  localparam int MW  = PW + 1;
  localparam int FW  = PW + MW;
  localparam logic [64:0] RECIP_FULL =
    ((65'd1 << RS) + 65'(PARAM_SCALE - 1)) / 65'(PARAM_SCALE);
  localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

  typedef struct packed {
    logic                 ok;
    logic signed [RW-1:0] u1;
    logic signed [RW-1:0] u2;
  } ust_t;

  function automatic ust_t edge_step(ust_t s, logic pneg, logic pzero, logic qneg,
                                     logic signed [RW-1:0] r);
    ust_t n;
    n = s;
    if (s.ok) begin
      if (pzero) begin
        if (qneg) n.ok = 1'b0;
      end else if (pneg) begin
        if (r > s.u2) n.ok = 1'b0;
        else if (r > s.u1) n.u1 = r;
      end else begin
        if (r < s.u1) n.ok = 1'b0;
        else if (r < s.u2) n.u2 = r;
      end
    end
    return n;
  endfunction

  function automatic logic signed [RW-1:0] clamp_r(logic [QW-1:0] mag, logic neg);
    logic [QW-1:0] lim;
    lim = QW'(PARAM_SCALE + 1);
    if (neg) return (mag != '0) ? {RW{1'b1}} : '0;
    return (mag > lim) ? RW'(PARAM_SCALE + 1) : RW'(mag);
  endfunction

  function automatic logic [W-1:0] mag_of(logic signed [W:0] v);
    logic [W:0] a;
    a = v[W] ? (~v + 1'b1) : v;
    return a[W-1:0];
  endfunction

  // window registers
  logic signed [W-1:0] win_left_q, win_right_q, win_bottom_q, win_top_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_left_q   <= W'(lswc_pkg::WIN_LEFT_RST);
      win_right_q  <= W'(lswc_pkg::WIN_RIGHT_RST);
      win_bottom_q <= W'(lswc_pkg::WIN_BOTTOM_RST);
      win_top_q    <= W'(lswc_pkg::WIN_TOP_RST);
    end else if (cfg_we_i) begin
      case (lswc_pkg::cfg_reg_e'(cfg_idx_i))
        lswc_pkg::REG_WINDOW_LEFT:   win_left_q   <= cfg_wdata_i;
        lswc_pkg::REG_WINDOW_RIGHT:  win_right_q  <= cfg_wdata_i;
        lswc_pkg::REG_WINDOW_BOTTOM: win_bottom_q <= cfg_wdata_i;
        lswc_pkg::REG_WINDOW_TOP:    win_top_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;

  // stage 1: edge p and q
  logic                v1_q;
  logic signed [W-1:0] x1_1q, y1_1q, x2_1q, y2_1q;
  logic signed [W:0]   p_1q [4];
  logic signed [W:0]   q_1q [4];
  logic signed [W:0]   ex1, ey1, ex2, ey2;

  assign ex1 = {start_x_i[W-1], start_x_i};
  assign ey1 = {start_y_i[W-1], start_y_i};
  assign ex2 = {end_x_i[W-1], end_x_i};
  assign ey2 = {end_y_i[W-1], end_y_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else         v1_q <= start_i;
  end

  always_ff @(posedge clk_i) begin
    x1_1q <= start_x_i;
    y1_1q <= start_y_i;
    x2_1q <= end_x_i;
    y2_1q <= end_y_i;
    p_1q[0] <= ex1 - ex2;
    q_1q[0] <= ex1 - {win_left_q[W-1], win_left_q};
    p_1q[1] <= ex2 - ex1;
    q_1q[1] <= {win_right_q[W-1], win_right_q} - ex1;
    p_1q[2] <= ey1 - ey2;
    q_1q[2] <= ey1 - {win_bottom_q[W-1], win_bottom_q};
    p_1q[3] <= ey2 - ey1;
    q_1q[3] <= {win_top_q[W-1], win_top_q} - ey1;
  end

  // stage 2: magnitudes and scaled numerator
  logic                v2_q;
  logic signed [W-1:0] x1_2q, y1_2q, x2_2q, y2_2q;
  logic [3:0]          pneg_2q, pzero_2q, qneg_2q;
  logic [W-1:0]        pmag_2q [4];
  logic [QW-1:0]       num_2q  [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else         v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    x1_2q <= x1_1q;
    y1_2q <= y1_1q;
    x2_2q <= x2_1q;
    y2_2q <= y2_1q;
    for (int e = 0; e < 4; e++) begin
      pneg_2q[e]  <= p_1q[e][W];
      pzero_2q[e] <= p_1q[e] == '0;
      qneg_2q[e]  <= q_1q[e][W];
      pmag_2q[e]  <= mag_of(p_1q[e]);
      num_2q[e]   <= QW'(mag_of(q_1q[e])) * QW'(PARAM_SCALE);
    end
  end

  logic [QW-1:0]  rmag [4];
  logic [SB1-1:0] sb1_in, sb1_out;

  for (genvar e = 0; e < 4; e++) begin : g_edge_div
    lswc_div #(.DW(QW), .VW(W)) u_div (
      .clk_i (clk_i),
      .num_i (num_2q[e]),
      .den_i (pmag_2q[e]),
      .quo_o (rmag[e])
    );
  end

  assign sb1_in = {v2_q, x1_2q, y1_2q, x2_2q, y2_2q, pneg_2q, pzero_2q, qneg_2q};

  lswc_pipe #(.WIDTH(SB1), .DEPTH(QW + 1)) u_sb1 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .data_i (sb1_in),
    .data_o (sb1_out)
  );

  logic                v_d1;
  logic signed [W-1:0] x1_d1, y1_d1, x2_d1, y2_d1;
  logic [3:0]          pneg_d1, pzero_d1, qneg_d1;

  assign {v_d1, x1_d1, y1_d1, x2_d1, y2_d1, pneg_d1, pzero_d1, qneg_d1} = sb1_out;

  // stage 3: signed, clamped edge parameters
  logic                 v3_q;
  logic signed [W-1:0]  x1_3q, y1_3q, x2_3q, y2_3q;
  logic [3:0]           pneg_3q, pzero_3q, qneg_3q;
  logic signed [RW-1:0] r_3q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else         v3_q <= v_d1;
  end

  always_ff @(posedge clk_i) begin
    x1_3q <= x1_d1;
    y1_3q <= y1_d1;
    x2_3q <= x2_d1;
    y2_3q <= y2_d1;
    pneg_3q  <= pneg_d1;
    pzero_3q <= pzero_d1;
    qneg_3q  <= qneg_d1;
    for (int e = 0; e < 4; e++) r_3q[e] <= clamp_r(rmag[e], pneg_d1[e] ^ qneg_d1[e]);
  end

  // stage 4: left and right edges
  logic                 v4_q;
  logic signed [W-1:0]  x1_4q, y1_4q, x2_4q, y2_4q;
  logic [1:0]           pneg_4q, pzero_4q, qneg_4q;
  logic signed [RW-1:0] r_4q [2];
  ust_t                 us_4q, us_init, us_a, us_4d;

  assign us_init = '{ok: 1'b1, u1: '0, u2: RW'(PARAM_SCALE)};
  assign us_a    = edge_step(us_init, pneg_3q[0], pzero_3q[0], qneg_3q[0], r_3q[0]);
  assign us_4d   = edge_step(us_a, pneg_3q[1], pzero_3q[1], qneg_3q[1], r_3q[1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else         v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    x1_4q <= x1_3q;
    y1_4q <= y1_3q;
    x2_4q <= x2_3q;
    y2_4q <= y2_3q;
    pneg_4q  <= pneg_3q[3:2];
    pzero_4q <= pzero_3q[3:2];
    qneg_4q  <= qneg_3q[3:2];
    r_4q[0]  <= r_3q[2];
    r_4q[1]  <= r_3q[3];
    us_4q    <= us_4d;
  end

  // stage 5: bottom and top edges
  logic                v5_q;
  logic signed [W-1:0] x1_5q, y1_5q, x2_5q, y2_5q;
  ust_t                us_5q, us_b, us_5d;

  assign us_b  = edge_step(us_4q, pneg_4q[0], pzero_4q[0], qneg_4q[0], r_4q[0]);
  assign us_5d = edge_step(us_b, pneg_4q[1], pzero_4q[1], qneg_4q[1], r_4q[1]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else         v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    x1_5q <= x1_4q;
    y1_5q <= y1_4q;
    x2_5q <= x2_4q;
    y2_5q <= y2_4q;
    us_5q <= us_5d;
  end

  // stage 6: endpoint products
  logic                v6_q;
  logic signed [W-1:0] x1_6q, y1_6q, x2_6q, y2_6q;
  logic                ok_6q, m1_6q, m2_6q, dxneg_6q, dyneg_6q;
  logic [PW-1:0]       prod_6q [4];
  logic signed [W:0]   dx5, dy5;
  logic [W-1:0]        adx5, ady5;
  logic [SW-1:0]       u1u, u2u;

  assign dx5  = {x2_5q[W-1], x2_5q} - {x1_5q[W-1], x1_5q};
  assign dy5  = {y2_5q[W-1], y2_5q} - {y1_5q[W-1], y1_5q};
  assign adx5 = mag_of(dx5);
  assign ady5 = mag_of(dy5);
  assign u1u  = us_5q.u1[SW-1:0];
  assign u2u  = us_5q.u2[SW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else         v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    x1_6q <= x1_5q;
    y1_6q <= y1_5q;
    x2_6q <= x2_5q;
    y2_6q <= y2_5q;
    ok_6q    <= us_5q.ok;
    m1_6q    <= us_5q.u1 > 0;
    m2_6q    <= us_5q.u2 < RW'(PARAM_SCALE);
    dxneg_6q <= dx5[W];
    dyneg_6q <= dy5[W];
    prod_6q[0] <= PW'(u1u) * PW'(adx5);
    prod_6q[1] <= PW'(u1u) * PW'(ady5);
    prod_6q[2] <= PW'(u2u) * PW'(adx5);
    prod_6q[3] <= PW'(u2u) * PW'(ady5);
  end

  // stage 7: endpoint rescale by reciprocal multiplication
  logic [PW-1:0]  omag_q [4];
  logic [FW-1:0]  rprod  [4];
  logic [SB2-1:0] sb2_in, sb2_out;

  always_comb begin
    for (int k = 0; k < 4; k++) rprod[k] = FW'(prod_6q[k]) * FW'(RECIP);
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) omag_q[k] <= PW'(rprod[k] >> RS);
  end

  assign sb2_in = {v6_q, ok_6q, m1_6q, m2_6q, dxneg_6q, dyneg_6q,
                   x1_6q, y1_6q, x2_6q, y2_6q};

  lswc_pipe #(.WIDTH(SB2), .DEPTH(1)) u_sb2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .data_i (sb2_in),
    .data_o (sb2_out)
  );

  logic                v_d2, ok_d2, m1_d2, m2_d2, dxneg_d2, dyneg_d2;
  logic signed [W-1:0] x1_d2, y1_d2, x2_d2, y2_d2;
  logic signed [W:0]   off [4];
  logic signed [W:0]   sx, sy, ex, ey;

  assign {v_d2, ok_d2, m1_d2, m2_d2, dxneg_d2, dyneg_d2, x1_d2, y1_d2, x2_d2, y2_d2} = sb2_out;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      off[k] = (W + 1)'(omag_q[k]);
      if ((k % 2 == 0) ? dxneg_d2 : dyneg_d2) off[k] = -off[k];
    end
    sx = m1_d2 ? {x1_d2[W-1], x1_d2} + off[0] : {x1_d2[W-1], x1_d2};
    sy = m1_d2 ? {y1_d2[W-1], y1_d2} + off[1] : {y1_d2[W-1], y1_d2};
    ex = m2_d2 ? {x1_d2[W-1], x1_d2} + off[2] : {x2_d2[W-1], x2_d2};
    ey = m2_d2 ? {y1_d2[W-1], y1_d2} + off[3] : {y2_d2[W-1], y2_d2};
  end

  // stage 8: result beat
  logic done_q, vis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      vis_q  <= 1'b0;
    end else begin
      done_q <= v_d2;
      vis_q  <= v_d2 && ok_d2;
    end
  end

  always_ff @(posedge clk_i) begin
    clip_start_x_o <= ok_d2 ? sx[W-1:0] : '0;
    clip_start_y_o <= ok_d2 ? sy[W-1:0] : '0;
    clip_end_x_o   <= ok_d2 ? ex[W-1:0] : '0;
    clip_end_y_o   <= ok_d2 ? ey[W-1:0] : '0;
  end

  assign done_o    = done_q;
  assign visible_o = vis_q;

endmodule

// ===== hw/rtl/lswc_checker.sv =====
module lswc_checker #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   busy_o,
  input logic                   done_o,
  input logic                   visible_o,
  input logic [COORD_WIDTH-1:0] clip_start_x_o,
  input logic [COORD_WIDTH-1:0] clip_start_y_o,
  input logic [COORD_WIDTH-1:0] clip_end_x_o,
  input logic [COORD_WIDTH-1:0] clip_end_y_o
);

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !visible_o |-> clip_start_x_o == '0 && clip_start_y_o == '0 &&
                             clip_end_x_o == '0 && clip_end_y_o == '0)
    else $error("rejected beat carries nonzero coordinates");

  a_visible_only_on_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> !visible_o)
    else $error("visible raised without a result beat");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(done_o) |-> !busy_o)
    else $error("pipeline stalled behind a result beat");

endmodule

bind line_segment_window_clipper lswc_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lswc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .visible_o      (visible_o),
  .clip_start_x_o (clip_start_x_o),
  .clip_start_y_o (clip_start_y_o),
  .clip_end_x_o   (clip_end_x_o),
  .clip_end_y_o   (clip_end_y_o)
);

// ===== bench/line_segment_window_clipper_tb.sv =====
module line_segment_window_clipper_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = lswc_pkg::COORD_WIDTH_DEF;
  localparam longint SCALE = lswc_pkg::PARAM_SCALE_DEF;
  localparam int LATENCY = 35;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    logic   visible;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } clip_res_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start_i = 1'b0;
  logic   busy_o;
  coord_t start_x_i = '0;
  coord_t start_y_i = '0;
  coord_t end_x_i = '0;
  coord_t end_y_i = '0;
  logic   cfg_we_i = 1'b0;
  logic [lswc_pkg::CFG_IDX_WIDTH-1:0] cfg_idx_i = '0;
  logic [CW-1:0] cfg_wdata_i = '0;
  logic   done_o;
  logic   visible_o;
  coord_t clip_start_x_o, clip_start_y_o, clip_end_x_o, clip_end_y_o;

  coord_t win_l = coord_t'(lswc_pkg::WIN_LEFT_RST);
  coord_t win_r = coord_t'(lswc_pkg::WIN_RIGHT_RST);
  coord_t win_b = coord_t'(lswc_pkg::WIN_BOTTOM_RST);
  coord_t win_t = coord_t'(lswc_pkg::WIN_TOP_RST);

  clip_res_t clipped_q[$];
  int errors = 0;
  int send_idle_pct = 0;

  line_segment_window_clipper u_dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("** line_segment_window_clipper: FAILED **");
    $finish;
  end

  function automatic bit edge_ok(longint p, longint q, ref longint u1, ref longint u2);
    longint r;
    if (p < 0) begin
      r = (q * SCALE) / p;
      if (r > u2) return 0;
      if (r > u1) u1 = r;
    end else if (p > 0) begin
      r = (q * SCALE) / p;
      if (r < u1) return 0;
      if (r < u2) u2 = r;
    end else if (q < 0) begin
      return 0;
    end
    return 1;
  endfunction

  function automatic clip_res_t clip_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    longint x1, y1, dx, dy, u1, u2;
    clip_res_t res;
    x1 = ax;
    y1 = ay;
    dx = longint'(bx) - x1;
    dy = longint'(by) - y1;
    u1 = 0;
    u2 = SCALE;
    res = '0;
    if (!(edge_ok(-dx, x1 - win_l, u1, u2) && edge_ok(dx, win_r - x1, u1, u2) &&
          edge_ok(-dy, y1 - win_b, u1, u2) && edge_ok(dy, win_t - y1, u1, u2)))
      return res;
    res.visible = 1'b1;
    res.sx = ax;
    res.sy = ay;
    res.ex = bx;
    res.ey = by;
    if (u1 > 0) begin
      res.sx = coord_t'(x1 + (u1 * dx) / SCALE);
      res.sy = coord_t'(y1 + (u1 * dy) / SCALE);
    end
    if (u2 < SCALE) begin
      res.ex = coord_t'(x1 + (u2 * dx) / SCALE);
      res.ey = coord_t'(y1 + (u2 * dy) / SCALE);
    end
    return res;
  endfunction

  task automatic send_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    start_x_i <= ax;
    start_y_i <= ay;
    end_x_i   <= bx;
    end_y_i   <= by;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    clipped_q.push_back(clip_segment(ax, ay, bx, by));
  endtask

  task automatic drain;
    start_i <= 1'b0;
    @(posedge clk_i);
    while (clipped_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_window(lswc_pkg::cfg_reg_e idx, coord_t val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      lswc_pkg::REG_WINDOW_LEFT:   win_l = val;
      lswc_pkg::REG_WINDOW_RIGHT:  win_r = val;
      lswc_pkg::REG_WINDOW_BOTTOM: win_b = val;
      lswc_pkg::REG_WINDOW_TOP:    win_t = val;
      default: ;
    endcase
  endtask

  task automatic set_window(coord_t l, coord_t r, coord_t b, coord_t t);
    drain();
    write_window(lswc_pkg::REG_WINDOW_LEFT, l);
    write_window(lswc_pkg::REG_WINDOW_RIGHT, r);
    write_window(lswc_pkg::REG_WINDOW_BOTTOM, b);
    write_window(lswc_pkg::REG_WINDOW_TOP, t);
    cfg_we_i <= 1'b0;
  endtask

  function automatic coord_t near_coord(coord_t lo, coord_t hi);
    longint a, b;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    a = a - 64;
    b = b + 64;
    if (a < -32768) a = -32768;
    if (b > 32767) b = 32767;
    return coord_t'(a + longint'($urandom_range(32'(b - a))));
  endfunction

  always @(posedge clk_i) begin
    clip_res_t exp_res;
    clip_res_t got;
    if (rst_ni && done_o) begin
      got = '{visible_o, clip_start_x_o, clip_start_y_o, clip_end_x_o, clip_end_y_o};
      if (clipped_q.size() == 0) begin
        $display("%0t: unexpected beat %p", $time, got);
        errors++;
      end else begin
        exp_res = clipped_q.pop_front();
        if (got !== exp_res) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_res, got);
          errors++;
        end
      end
    end
  end

  task automatic test_directed;
    send_segment(-10, 120, 400, 120);
    send_segment(160, -50, 160, 300);
    send_segment(-100, -100, 500, 400);
    send_segment(50, 50, 100, 100);
    send_segment(100, 100, 100, 100);
    send_segment(-5, 100, -5, 100);
    send_segment(-5, 10, -5, 200);
    send_segment(10, 300, 200, 300);
    send_segment(400, 10, 500, 200);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(-32768, 120, 32767, 120);
    send_segment(0, 0, 320, 240);
    send_segment(320, 240, 0, 0);
    send_segment(-1, -1, -1, -1);
    send_segment(32767, 32767, 32767, 32767);
    send_segment(-32768, -32768, -32768, -32768);
    send_segment(-50, 300, 400, -60);
    set_window(-32768, 32767, -32768, 32767);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, 32767, -32768, -32768);
    set_window(100, 50, 0, 240);
    send_segment(0, 10, 200, 10);
    send_segment(75, 10, 75, 10);
    set_window(0, 320, 200, 100);
    send_segment(10, 0, 10, 300);
  endtask

  task automatic test_random(int count);
    coord_t a, b, c, d;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(4) == 0) begin
        a = coord_t'($urandom);
        b = coord_t'($urandom);
        c = coord_t'($urandom);
        d = coord_t'($urandom);
      end else begin
        a = near_coord(win_l, win_r);
        b = near_coord(win_b, win_t);
        c = ($urandom_range(5) == 0) ? a : near_coord(win_l, win_r);
        d = ($urandom_range(5) == 0) ? b : near_coord(win_b, win_t);
      end
      send_segment(a, b, c, d);
    end
  endtask

  task automatic test_windows(int per_window);
    coord_t l, r, b, t;
    for (int w = 0; w < 6; w++) begin
      l = coord_t'($urandom);
      r = coord_t'($urandom);
      b = coord_t'($urandom);
      t = coord_t'($urandom);
      if ($urandom_range(3) != 0) begin
        if (l > r) {l, r} = {r, l};
        if (b > t) {b, t} = {t, b};
      end
      set_window(l, r, b, t);
      test_random(per_window);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 10;
    test_directed();
    set_window(coord_t'(lswc_pkg::WIN_LEFT_RST), coord_t'(lswc_pkg::WIN_RIGHT_RST),
               coord_t'(lswc_pkg::WIN_BOTTOM_RST), coord_t'(lswc_pkg::WIN_TOP_RST));
    test_random(250);
    test_windows(40);
    send_idle_pct = 81;
    set_window(-200, 200, -150, 150);
    test_random(250);
    test_windows(40);
    send_idle_pct = 0;
    set_window(-32768, 32767, -32768, 32767);
    test_random(300);
    test_windows(40);
    start_i <= 1'b0;
    for (int k = 0; k < 20 * LATENCY && clipped_q.size() != 0; k++) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
    if (errors == 0 && clipped_q.size() == 0) begin
      $display("** line_segment_window_clipper: PASSED **");
    end else begin
      $display("** line_segment_window_clipper: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lswc_pkg.sv
hw/rtl/lswc_div.sv
hw/rtl/lswc_pipe.sv
hw/rtl/line_segment_window_clipper.sv
hw/rtl/lswc_checker.sv
bench/line_segment_window_clipper_tb.sv
